// File: design/nct_pkg.sv
// Shared types, codes and default sizes for the named counter table.
package nct_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int KEY_BITS_DEF      = 32;
  localparam int KEY_ID_W          = 32;
  localparam int COUNT_W           = 64;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_CREATED  = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]                mode;
    logic [KEY_ID_W-1:0]       key_id;
    logic signed [COUNT_W-1:0] delta;
  } nct_in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] value;
    logic [1:0]                status;
  } nct_out_t;

endpackage

// File: design/named_counter_table.sv
// Named counter table: key match cells, counter memory and result register.
//
//   channel  | direction | handshake            | word
//   in_      | input     | in_valid / in_ready   | nct_in_t  (mode, key_id, delta)
//   out_     | output    | out_valid / out_ready | nct_out_t (value, status)
//
// Each word passes a lookup state, in which every used key cell is matched at
// once and the counter memory is read, and then an update state, in which the
// 64-bit add is formed and the result is loaded; an add that finds room also
// writes its sum back. A new word is accepted in the update state of the one
// before it, as that result loads. Reset empties the table at once; there is
// no clearing pass. A held result stalls the block in its update state only.
module named_counter_table #(
  parameter int TABLE_ENTRIES = nct_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = nct_pkg::KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nct_pkg::nct_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nct_pkg::nct_out_t out_data
);
  import nct_pkg::*;

  // Key id bits above KEY_BITS never take part, so the cells hold only these.
  localparam int KW    = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  nct_in_t             req_r;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [KW-1:0]       key_cells [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  count_mem [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  rd_data_r;

  logic [KW-1:0]       req_key;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic                look_hit;
  logic [IDX_W-1:0]    look_idx;
  logic                has_room;
  logic                look_create;
  logic                look_full;

  logic                hit_r, create_r, full_r;
  logic [IDX_W-1:0]    idx_r;

  logic                out_valid_r;
  nct_out_t            out_data_r, out_data_nxt;
  logic                out_can_load;
  logic                out_load;
  logic                mem_we;
  logic [COUNT_W-1:0]  sum;

  assign req_key  = req_r.key_id[KW-1:0];
  assign has_room = (used_r < CNT_W'(TABLE_ENTRIES));

  // Keys in the table are unique, so at most one cell matches and the index
  // can be formed by OR-ing without a priority encoder.
  always_comb begin
    look_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = (key_cells[i] == req_key) && (CNT_W'(i) < used_r);
      if (hit_vec[i]) begin
        look_idx = look_idx | IDX_W'(i);
      end
    end
    look_hit    = |hit_vec;
    look_create = (req_r.mode == MODE_ADD) && !look_hit && has_room;
    look_full   = (req_r.mode == MODE_ADD) && !look_hit && !has_room;
  end

  assign out_can_load = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE) || ((state_r == S_UPD) && out_can_load);
  assign out_load     = (state_r == S_UPD) && out_can_load;
  assign mem_we       = out_load && (req_r.mode == MODE_ADD) && !full_r;

  // A fresh entry starts from zero whatever the memory holds there.
  assign sum = (create_r ? '0 : rd_data_r) + COUNT_W'(req_r.delta);

  always_comb begin
    out_data_nxt.value  = '0;
    out_data_nxt.status = ST_EXISTING;
    unique case (req_r.mode)
      MODE_ADD: begin
        if (full_r) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          out_data_nxt.value  = sum;
          out_data_nxt.status = create_r ? ST_CREATED : ST_EXISTING;
        end
      end
      MODE_GET: begin
        if (hit_r) begin
          out_data_nxt.value = rd_data_r;
        end else begin
          out_data_nxt.status = ST_MISS;
        end
      end
      default: begin
        out_data_nxt.value  = '0;
        out_data_nxt.status = ST_EXISTING;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_UPD;
        if (req_r.mode == MODE_CLEAR) begin
          used_nxt = '0;
        end else if (look_create) begin
          used_nxt = used_r + CNT_W'(1);
        end
      end
      S_UPD: begin
        if (out_can_load) begin
          state_nxt = in_valid ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (state_r == S_LOOK) begin
      hit_r    <= look_hit;
      create_r <= look_create;
      full_r   <= look_full;
      idx_r    <= look_create ? used_r[IDX_W-1:0] : look_idx;
      if (look_create) begin
        key_cells[used_r[IDX_W-1:0]] <= req_key;
      end
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[idx_r] <= sum;
    end
    rd_data_r <= count_mem[look_idx];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_ENTRIES))
    else $error("used count exceeds table size");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOOK)
    else $error("accepted word did not enter lookup");

  a_used_only_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(used_r) |-> $past(state_r) == S_LOOK)
    else $error("used count changed outside lookup");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_FULL || out_data_r.status == ST_MISS)
      |-> out_data_r.value == '0)
    else $error("dropped add or miss carries a value");

  a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) && look_create |=> used_r == $past(used_r) + CNT_W'(1))
    else $error("entry created without growing the used count");

endmodule
